// ===== rtl/lmnm_pkg.sv =====
package lmnm_pkg;

    // Field widths
    localparam int COORD_W   = 12;   // candidate point, whole pixels
    localparam int FRAC_W    = 4;    // fraction bits of the Q12.4 query
    localparam int QCOORD_W  = COORD_W + FRAC_W;
    localparam int NUM_LANES = 3;    // left eye, right eye, mouth
    localparam int NUM_REGS  = 2 * NUM_LANES;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);

    // Distance arithmetic
    localparam int SQ_W      = 2 * QCOORD_W;          // one squared difference
    localparam int VAL_W     = SQ_W + 2;              // sum of two squares, even width
    localparam int ROOT_W    = VAL_W / 2;             // integer root width
    localparam int REM_W     = ROOT_W + 3;            // partial remainder width
    localparam int ITER_W    = $clog2(ROOT_W);
    localparam int DIST_W    = 21;                    // sum of three roots
    localparam logic [DIST_W-1:0] INIT_BOUND = DIST_W'(1599984);

    // Search bookkeeping
    localparam int MAX_CANDIDATES = 65536;
    localparam int IDX_W          = 16;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CANDIDATES - 1);

    // Stream payload widths
    localparam int IN_DATA_W  = ((2 * NUM_LANES * COORD_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + IDX_W + DIST_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LE_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LE_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RE_X = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RE_Y = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MO_X = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_MO_Y = CFG_IDX_W'(5);

    localparam logic [CFG_IDX_W-1:0] LANE_QX_REG [NUM_LANES] = '{REG_LE_X, REG_RE_X, REG_MO_X};
    localparam logic [CFG_IDX_W-1:0] LANE_QY_REG [NUM_LANES] = '{REG_LE_Y, REG_RE_Y, REG_MO_Y};

    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [QCOORD_W-1:0] t_qcoord;
    typedef logic [ROOT_W-1:0]   t_root;

    // Request from the top level to one lane
    typedef struct packed {
        logic    start;
        t_qcoord qx;
        t_qcoord qy;
        t_coord  cx;
        t_coord  cy;
    } t_lane_req;

    // Status from one lane back to the top level
    typedef struct packed {
        logic  done;
        t_root root;
    } t_lane_status;

    // Absolute difference of a query coordinate and a widened candidate coordinate
    function automatic t_qcoord abs_diff(input t_qcoord q, input t_coord c);
        t_qcoord cw;
        cw = {c, {FRAC_W{1'b0}}};
        return (q >= cw) ? (q - cw) : (cw - q);
    endfunction

endpackage

// ===== rtl/lmnm_lane.sv =====
module lmnm_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lmnm_pkg::t_lane_req    i_req,
    output lmnm_pkg::t_lane_status o_status
);
    import lmnm_pkg::*;

    typedef enum logic [1:0] {L_IDLE, L_MUL, L_SUM, L_ROOT} t_lstate;

    t_lstate             r_state;
    logic                r_done;
    logic [ITER_W-1:0]   r_iter;
    t_qcoord             r_dx;
    t_qcoord             r_dy;
    logic [SQ_W-1:0]     r_sqx;
    logic [SQ_W-1:0]     r_sqy;
    logic [VAL_W-1:0]    r_val;
    logic [REM_W-1:0]    r_rem;
    t_root               r_root;

    logic [REM_W-1:0]    n_rem_shift;
    logic [REM_W-1:0]    n_trial;
    logic                n_take;

    // One digit of the restoring square root: bring down two bits, try 4q+1.
    assign n_rem_shift = {r_rem[REM_W-3:0], r_val[VAL_W-1 -: 2]};
    assign n_trial     = {1'b0, r_root, 2'b01};
    assign n_take      = (n_rem_shift >= n_trial);

    // Sequencer: difference, square, sum, then one root digit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
            r_iter  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_req.start) begin
                        r_dx    <= abs_diff(i_req.qx, i_req.cx);
                        r_dy    <= abs_diff(i_req.qy, i_req.cy);
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_sqx   <= SQ_W'(r_dx) * SQ_W'(r_dx);
                    r_sqy   <= SQ_W'(r_dy) * SQ_W'(r_dy);
                    r_state <= L_SUM;
                end
                L_SUM: begin
                    r_val   <= VAL_W'(r_sqx) + VAL_W'(r_sqy);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_iter  <= '0;
                    r_state <= L_ROOT;
                end
                L_ROOT: begin
                    r_val  <= {r_val[VAL_W-3:0], 2'b00};
                    r_rem  <= n_take ? (n_rem_shift - n_trial) : n_rem_shift;
                    r_root <= {r_root[ROOT_W-2:0], n_take};
                    r_iter <= r_iter + ITER_W'(1);
                    if (r_iter == ITER_W'(ROOT_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_status.done = r_done;
    assign o_status.root = r_root;

endmodule

// ===== rtl/lmnm_merge.sv =====
module lmnm_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step,
    input  logic                               i_last,
    input  lmnm_pkg::t_root                    i_roots [lmnm_pkg::NUM_LANES],
    output logic                               o_tvalid,
    input  logic                               i_tready,
    // Fields from bit 0 up: match_found, best_index, best_distance, zero fill
    output logic [lmnm_pkg::OUT_DATA_W-1:0]    o_tdata
);
    import lmnm_pkg::*;

    logic [DIST_W-1:0] r_best_dist;
    logic [IDX_W-1:0]  r_best_idx;
    logic [IDX_W-1:0]  r_count;
    logic              r_any;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_match;

    logic [DIST_W-1:0] n_sum;
    logic              n_better;
    logic [DIST_W-1:0] n_best_dist;
    logic [IDX_W-1:0]  n_best_idx;
    logic              n_any;

    // Add the three lane distances and compare with the running minimum.
    always_comb begin
        n_sum = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_sum = n_sum + DIST_W'(i_roots[l]);
        end
        n_better    = (n_sum < r_best_dist);
        n_best_dist = n_better ? n_sum   : r_best_dist;
        n_best_idx  = n_better ? r_count : r_best_idx;
        n_any       = n_better | r_any;
    end

    // Search state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist <= INIT_BOUND;
            r_best_idx  <= '0;
            r_count     <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step && i_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_step) begin
                if (i_last) begin
                    r_out_dist  <= n_best_dist;
                    r_out_idx   <= n_best_idx;
                    r_out_match <= n_any;
                    r_best_dist <= INIT_BOUND;
                    r_best_idx  <= '0;
                    r_count     <= '0;
                    r_any       <= 1'b0;
                end else begin
                    r_best_dist <= n_best_dist;
                    r_best_idx  <= n_best_idx;
                    r_any       <= n_any;
                    r_count     <= (r_count == IDX_LAST) ? '0 : r_count + IDX_W'(1);
                end
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = OUT_DATA_W'({r_out_dist, r_out_idx, r_out_match});

endmodule

// ===== rtl/landmark_nearest_match.sv =====
// Each candidate passes through difference, square and sum, then 17 bit-serial root steps in
// each lane; the control then sees the lanes finish and merges, and a last candidate's merge
// waits until m_axis is free. A new candidate is taken only once the previous one is merged.
// A result waits in the output register while the next candidate is taken.
// Reset (i_rst_n low at a clock edge) returns the search to its initial bound, drops any
// waiting result and clears the query registers to zero.
module landmark_nearest_match (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Fields from bit 0 up: cand_left_eye_x, cand_left_eye_y, cand_right_eye_x,
    // cand_right_eye_y, cand_mouth_x, cand_mouth_y
    input  logic [lmnm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic                                 s_axis_tlast,
    // Fields from bit 0 up: match_found, best_index, best_distance, zero fill
    output logic [lmnm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lmnm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lmnm_pkg::QCOORD_W-1:0]        i_cfg_data
);
    import lmnm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_MERGE} t_state;

    t_state        r_state;
    logic          r_last;
    t_qcoord       r_query [NUM_REGS];

    logic          in_xfer;
    logic          lanes_done;
    logic          out_free;
    logic          merge_step;
    t_lane_req     lane_req    [NUM_LANES];
    t_lane_status  lane_status [NUM_LANES];
    t_root         lane_roots  [NUM_LANES];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign merge_step    = (r_state == S_MERGE) && (!r_last || out_free);

    // Query registers; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                r_query[r] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            r_query[i_cfg_index] <= i_cfg_data;
        end
    end

    // One lane per landmark.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        assign lane_req[g].start = in_xfer;
        assign lane_req[g].qx    = r_query[LANE_QX_REG[g]];
        assign lane_req[g].qy    = r_query[LANE_QY_REG[g]];
        assign lane_req[g].cx    = s_axis_tdata[(2*g)*COORD_W +: COORD_W];
        assign lane_req[g].cy    = s_axis_tdata[(2*g+1)*COORD_W +: COORD_W];
        assign lane_roots[g]     = lane_status[g].root;

        lmnm_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_req    (lane_req[g]),
            .o_status (lane_status[g])
        );
    end

    assign lanes_done = lane_status[0].done;

    // Item control: take a candidate, wait for the lanes, merge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_last  <= s_axis_tlast;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (lanes_done) begin
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    if (merge_step) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    lmnm_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (merge_step),
        .i_last   (r_last),
        .i_roots  (lane_roots),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

    // The lanes run in lockstep, so they finish together.
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_status[0].done == lane_status[1].done) &&
        (lane_status[0].done == lane_status[2].done))
        else $error("lanes finished out of step");

    // Lanes report only while an item is in flight.
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lanes_done |-> (r_state == S_RUN))
        else $error("lane finished with no item in flight");

    // A merged last candidate always presents a result next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (merge_step && r_last) |=> m_axis_tvalid)
        else $error("last candidate merged without a result");

    // A transfer in starts the lanes.
    a_xfer_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_RUN))
        else $error("accepted candidate did not start");

endmodule
